### hw/rtl/postings_list_delta_encoder_assert.svh
// assertion macros used by the postings encoder rtl
`ifndef POSTINGS_LIST_DELTA_ENCODER_ASSERT_SVH
`define POSTINGS_LIST_DELTA_ENCODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PLD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pld same-cycle check failed");

// next-cycle implication, checked outside reset
`define PLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pld next-cycle check failed");

`endif

### hw/rtl/pld_pkg.sv
// types and constants for the postings list delta encoder
package pld_pkg;

    localparam int unsigned NUM_SLOTS  = 7;
    localparam int unsigned SLOT_W     = 3;
    localparam int unsigned OFF_W      = 5;
    localparam logic [31:0] WORD_BYTES = 32'd4;
    localparam logic [47:0] COUNT_MAX  = 48'hFFFF_FFFF_FFFF;

    // input item kinds
    localparam logic KIND_OCCURRENCE = 1'b0;
    localparam logic KIND_END        = 1'b1;

    // write kinds
    localparam logic [1:0] WK_FRESH  = 2'd0;
    localparam logic [1:0] WK_PATCH  = 2'd1;
    localparam logic [1:0] WK_LENGTH = 2'd2;

    // fixed order of the writes one item may cause
    localparam logic [SLOT_W-1:0] SLOT_FREQ_PATCH  = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_COUNT_PATCH = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_LENGTH      = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_COUNT_HOLD  = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_DOC_DELTA   = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_FREQ_HOLD   = 3'd5;
    localparam logic [SLOT_W-1:0] SLOT_POS_DELTA   = 3'd6;

    typedef struct packed {
        logic        kind;
        logic [63:0] term_hash;
        logic [31:0] doc_id;
        logic [31:0] word_position;
    } t_in_item;

    typedef struct packed {
        logic [31:0] write_address;
        logic [31:0] write_value;
        logic [1:0]  write_kind;
        logic        last;
        logic [47:0] postings_so_far;
    } t_out_item;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] value;
        logic [1:0]  kind;
    } t_write;

    typedef struct packed {
        logic [63:0] open_term;
        logic        term_active;
        logic        doc_active;
        logic [31:0] open_doc;
        logic [31:0] previous_doc;
        logic [31:0] previous_position;
        logic [31:0] docs_in_term;
        logic [31:0] hits_in_doc;
        logic [31:0] freq_slot_address;
        logic [31:0] block_start;
        logic [31:0] next_free_address;
        logic [47:0] postings_count;
    } t_state;

endpackage

### hw/rtl/pld_plan.sv
// per-item write plan and next encoder state
module pld_plan (
    input  pld_pkg::t_state                      i_state,
    input  pld_pkg::t_in_item                    i_item,
    output logic [pld_pkg::NUM_SLOTS-1:0]        o_enable,
    output pld_pkg::t_write [pld_pkg::NUM_SLOTS-1:0] o_writes,
    output pld_pkg::t_state                      o_state_next
);
    import pld_pkg::*;

    logic             occ;
    logic             close_blk;
    logic             open_blk;
    logic             new_doc;
    logic             freq_patch;
    logic [31:0]      nf0;
    logic [OFF_W-1:0] off_open;
    logic [OFF_W-1:0] off_doc;
    logic [OFF_W-1:0] off_pos;
    logic [31:0]      prev_doc_eff;
    logic [31:0]      prev_pos_eff;
    logic [31:0]      docs_eff;
    logic [47:0]      count_next;

    always_comb begin
        occ        = (i_item.kind == KIND_OCCURRENCE);
        close_blk  = i_state.term_active &&
                     (!occ || (i_item.term_hash != i_state.open_term));
        open_blk   = occ && (!i_state.term_active || close_blk);
        new_doc    = occ && (open_blk || !i_state.doc_active ||
                     (i_item.doc_id != i_state.open_doc));
        // old document frequency goes out on a block close or a document change
        freq_patch = i_state.doc_active && (close_blk || new_doc);

        nf0      = i_state.next_free_address;
        off_open = close_blk ? OFF_W'(4) : OFF_W'(0);
        off_doc  = off_open + (open_blk ? OFF_W'(4) : OFF_W'(0));
        off_pos  = off_doc + (new_doc ? OFF_W'(8) : OFF_W'(0));

        prev_doc_eff = open_blk ? 32'd0 : i_state.previous_doc;
        prev_pos_eff = new_doc ? 32'd0 : i_state.previous_position;
        docs_eff     = open_blk ? 32'd0 : i_state.docs_in_term;

        if (occ && (i_state.postings_count != COUNT_MAX)) begin
            count_next = i_state.postings_count + 48'd1;
        end else begin
            count_next = i_state.postings_count;
        end

        o_enable = '0;
        o_enable[SLOT_FREQ_PATCH]  = freq_patch;
        o_enable[SLOT_COUNT_PATCH] = close_blk;
        o_enable[SLOT_LENGTH]      = close_blk;
        o_enable[SLOT_COUNT_HOLD]  = open_blk;
        o_enable[SLOT_DOC_DELTA]   = new_doc;
        o_enable[SLOT_FREQ_HOLD]   = new_doc;
        o_enable[SLOT_POS_DELTA]   = occ;

        o_writes[SLOT_FREQ_PATCH]  = '{addr: i_state.freq_slot_address,
                                       value: i_state.hits_in_doc, kind: WK_PATCH};
        o_writes[SLOT_COUNT_PATCH] = '{addr: i_state.block_start + WORD_BYTES,
                                       value: i_state.docs_in_term, kind: WK_PATCH};
        o_writes[SLOT_LENGTH]      = '{addr: i_state.block_start,
                                       value: nf0 - i_state.block_start - WORD_BYTES,
                                       kind: WK_LENGTH};
        o_writes[SLOT_COUNT_HOLD]  = '{addr: nf0 + 32'(off_open), value: 32'd0,
                                       kind: WK_FRESH};
        o_writes[SLOT_DOC_DELTA]   = '{addr: nf0 + 32'(off_doc),
                                       value: i_item.doc_id - prev_doc_eff, kind: WK_FRESH};
        o_writes[SLOT_FREQ_HOLD]   = '{addr: nf0 + 32'(off_doc) + WORD_BYTES,
                                       value: 32'd0, kind: WK_FRESH};
        o_writes[SLOT_POS_DELTA]   = '{addr: nf0 + 32'(off_pos),
                                       value: i_item.word_position - prev_pos_eff,
                                       kind: WK_FRESH};

        o_state_next = i_state;
        o_state_next.postings_count = count_next;
        if (close_blk) begin
            o_state_next.block_start = nf0;
            o_state_next.term_active = 1'b0;
            o_state_next.doc_active  = 1'b0;
        end
        if (occ) begin
            o_state_next.term_active       = 1'b1;
            o_state_next.doc_active        = 1'b1;
            o_state_next.previous_position = i_item.word_position;
            o_state_next.hits_in_doc       = new_doc ? 32'd1 : i_state.hits_in_doc + 32'd1;
            o_state_next.next_free_address = nf0 + 32'(off_pos) + WORD_BYTES;
        end else begin
            o_state_next.next_free_address = nf0 + 32'(off_open);
        end
        if (open_blk) begin
            o_state_next.open_term    = i_item.term_hash;
            o_state_next.docs_in_term = 32'd0;
            o_state_next.previous_doc = 32'd0;
        end
        if (new_doc) begin
            o_state_next.open_doc          = i_item.doc_id;
            o_state_next.previous_doc      = i_item.doc_id;
            o_state_next.docs_in_term      = docs_eff + 32'd1;
            o_state_next.freq_slot_address = nf0 + 32'(off_doc) + WORD_BYTES;
        end
    end

endmodule

### hw/rtl/postings_list_delta_encoder.sv
// postings list delta encoder top level
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_stall    | i_in_item  (pld_pkg::t_in_item)
//  out     | output    | o_out_valid / i_out_stall  | o_out_item (pld_pkg::t_out_item)
//
// an accepted item sits in the input register; the plan logic lists the up to seven
// writes it causes and, each cycle the output is free, one moves into the output register
// an item causes one write per enabled slot (1 for a plain occurrence, up to 7 on
// a term change); an end marker with no open term retires without writing anything
// the single output register sets the pace: one write per cycle while the output is not stalled
// reset clears the encoder state (next free address to 4) and both valid flags
// a stalled output holds its transfer and back-pressures the input register
`include "postings_list_delta_encoder_assert.svh"

module postings_list_delta_encoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  pld_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output pld_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);
    import pld_pkg::*;

    // input register and the slot cursor inside the current item
    logic                r_in_valid;
    t_in_item            r_item;
    logic [SLOT_W-1:0]   r_slot;
    t_state              r_state;

    // output register
    logic                r_out_valid;
    t_out_item           r_out_item;

    // plan for the held item
    logic [NUM_SLOTS-1:0] plan_enable;
    t_write [NUM_SLOTS-1:0] plan_writes;
    t_state               n_state;

    // slot selection
    logic [NUM_SLOTS-1:0] remain;
    logic [NUM_SLOTS-1:0] remain_after;
    logic [SLOT_W-1:0]    sel;
    logic                 any_left;
    logic                 is_last;
    logic                 out_free;
    logic                 emit;
    logic                 done;
    logic                 in_take;

    pld_plan u_plan (
        .i_state      (r_state),
        .i_item       (r_item),
        .o_enable     (plan_enable),
        .o_writes     (plan_writes),
        .o_state_next (n_state)
    );

    always_comb begin
        // writes not yet sent for this item
        for (int i = 0; i < NUM_SLOTS; i++) begin
            remain[i] = plan_enable[i] && (SLOT_W'(i) >= r_slot);
        end
        // lowest pending slot goes next
        sel = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (remain[i]) begin
                sel = SLOT_W'(i);
            end
        end
        any_left     = |remain;
        remain_after = remain;
        remain_after[sel] = 1'b0;
        is_last      = (remain_after == '0);

        out_free = !r_out_valid || !i_out_stall;
        emit     = r_in_valid && any_left && out_free;
        // item retires on its final write transfer, or at once if it writes nothing
        done     = r_in_valid && (!any_left || (emit && is_last));
        in_take  = i_in_valid && !o_in_stall;
    end

    assign o_in_stall  = r_in_valid && !done;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
            r_state     <= '{next_free_address: WORD_BYTES, default: '0};
        end else begin
            if (done) begin
                r_state <= n_state;
                r_slot  <= '0;
            end else if (emit) begin
                r_slot  <= sel + SLOT_W'(1);
            end

            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (done) begin
                r_in_valid <= 1'b0;
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= i_in_item;
        end
        if (emit) begin
            r_out_item.write_address   <= plan_writes[sel].addr;
            r_out_item.write_value     <= plan_writes[sel].value;
            r_out_item.write_kind      <= plan_writes[sel].kind;
            r_out_item.last            <= is_last;
            r_out_item.postings_so_far <= n_state.postings_count;
        end
    end

    // a cursor past the first slot means an item is still held
    `PLD_ASSERT_NOW(a_slot_needs_item, i_clk, i_rst_n, r_slot != '0, r_in_valid)
    // addresses stay word aligned
    `PLD_ASSERT_NOW(a_word_aligned, i_clk, i_rst_n, 1'b1,
        (r_state.next_free_address[1:0] == 2'b00) && (r_state.block_start[1:0] == 2'b00))
    // a retired item leaves the cursor at the first slot
    `PLD_ASSERT_NEXT(a_cursor_rewinds, i_clk, i_rst_n, done, r_slot == '0)
    // posting count never goes back
    `PLD_ASSERT_NEXT(a_count_monotonic, i_clk, i_rst_n, 1'b1,
        r_state.postings_count >= $past(r_state.postings_count))

endmodule
